@@ rtl/char_stream_lexer_core_assert.svh @@
// Assertion macros used by the lexer core.
`ifndef CHAR_STREAM_LEXER_CORE_ASSERT_SVH
`define CHAR_STREAM_LEXER_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define CSL_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("csl: invariant violated");

// Antecedent implies consequent in the same cycle.
`define CSL_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csl: implication violated");

`endif

@@ rtl/csl_pkg.sv @@
package csl_pkg;

	localparam int MAX_TOKEN = 32;
	localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
	localparam int CHAR_W    = 8;
	localparam int KIND_W    = 3;
	localparam int POS_W     = 6;
	localparam int KW_N      = 7;

	localparam logic [KIND_W-1:0] KIND_OP      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUNCT   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NUM     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd4;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd5;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_OP,
		CLS_PUNCT,
		CLS_DIGIT,
		CLS_LETTER,
		CLS_UNDER,
		CLS_OTHER
	} cls_t;

	// Per-cell control: load wins over shift.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// Append strobe seen by the keyword tracker.
	typedef struct packed {
		logic              append;
		logic [LEN_W-1:0]  pos;
		logic [CHAR_W-1:0] ch;
	} kw_ctl_t;

	function automatic cls_t char_class(input logic [CHAR_W-1:0] c);
		cls_t r;
		unique case (c)
			" ", 8'h0A, 8'h09:           r = CLS_SPACE;
			"+", "-", "*", "/", "=":     r = CLS_OP;
			"(", ")", "{", "}", ";", ",": r = CLS_PUNCT;
			"_":                         r = CLS_UNDER;
			default: begin
				if (c >= "0" && c <= "9")
					r = CLS_DIGIT;
				else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
					r = CLS_LETTER;
				else
					r = CLS_OTHER;
			end
		endcase
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] r;
		unique case (k)
			3'd0:    r = 3'd3; // int
			3'd1:    r = 3'd6; // return
			3'd2:    r = 3'd2; // if
			3'd3:    r = 3'd4; // else
			3'd4:    r = 3'd5; // while
			3'd5:    r = 3'd5; // float
			3'd6:    r = 3'd4; // char
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Keyword text stored reversed, so character 0 sits in the low byte.
	function automatic logic [CHAR_W-1:0] kw_byte(input logic [2:0] k, input logic [2:0] idx);
		logic [47:0] text;
		logic [CHAR_W-1:0] r;
		unique case (k)
			3'd0:    text = 48'("tni");
			3'd1:    text = 48'("nruter");
			3'd2:    text = 48'("fi");
			3'd3:    text = 48'("esle");
			3'd4:    text = 48'("elihw");
			3'd5:    text = 48'("taolf");
			3'd6:    text = 48'("rahc");
			default: text = 48'h0;
		endcase
		if (idx < 3'd6)
			r = text[{idx, 3'b000} +: CHAR_W];
		else
			r = '0;
		return r;
	endfunction

endpackage

@@ rtl/csl_cell.sv @@
// One character slot of the word buffer chain.
module csl_cell (
	input  logic                       clk,
	input  csl_pkg::cell_ctl_t         ctl,
	input  logic [csl_pkg::CHAR_W-1:0] load_ch,
	input  logic [csl_pkg::CHAR_W-1:0] shift_in,
	output logic [csl_pkg::CHAR_W-1:0] ch_q
);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ch_q <= load_ch;
		end else if (ctl.shift) begin
			ch_q <= shift_in;
		end
	end

endmodule

@@ rtl/csl_kw_track.sv @@
// Track, per keyword, whether the buffered word is still a prefix of it.
module csl_kw_track (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csl_pkg::kw_ctl_t          ctl,
	input  logic [csl_pkg::LEN_W-1:0] len,
	input  logic                      ovf,
	output logic                      is_kw
);

	logic [csl_pkg::KW_N-1:0] match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
		end else if (ctl.append) begin
			for (int k = 0; k < csl_pkg::KW_N; k++) begin
				match_q[k] <= (ctl.pos == '0 || match_q[k]) &&
					(ctl.pos < csl_pkg::LEN_W'(csl_pkg::kw_len(3'(k)))) &&
					(ctl.ch == csl_pkg::kw_byte(3'(k), ctl.pos[2:0]));
			end
		end
	end

	always_comb begin
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < csl_pkg::KW_N; k++) begin
			if (match_q[k] && len == csl_pkg::LEN_W'(csl_pkg::kw_len(3'(k))))
				hit = 1'b1;
		end
		is_kw = hit && !ovf;
	end

endmodule

@@ rtl/char_stream_lexer_core.sv @@
// Path: an operator, punctuation or stray-byte token passes from its accepted byte through ST_SINGLE
//   into the output register; a buffered run leaves through ST_EMIT after the byte or end mark that ends it.
// Input: a byte that extends a run or is whitespace leaves s_tready high; an item that ends
//   a run holds the input while each run character is emitted, and then for a following token.
// Reset: arst_n clears the sequencer, run length and output valid at once; the cells are not cleared.
module char_stream_lexer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] byte_req
	input  logic        s_tuser,  // [0] end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] character, [13:8] char_position, [15:14] zero
	output logic [4:0]  m_tuser,  // [2:0] token_kind, [3] token_end, [4] truncated
	output logic        m_tlast   // run_end
);

`include "char_stream_lexer_core_assert.svh"

	localparam int LEN_W  = csl_pkg::LEN_W;
	localparam int CHAR_W = csl_pkg::CHAR_W;
	localparam int KIND_W = csl_pkg::KIND_W;
	localparam int POS_W  = csl_pkg::POS_W;
	localparam int NCELL  = csl_pkg::MAX_TOKEN;

	typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_SINGLE} state_t;
	typedef enum logic [1:0] {MODE_IDLE, MODE_NUM, MODE_WORD} mode_t;
	typedef enum logic [1:0] {PEND_NONE, PEND_SINGLE, PEND_START} pend_t;

	state_t              state_q;
	mode_t               mode_q;
	logic [LEN_W-1:0]    len_q;
	logic                ovf_q;
	logic [LEN_W-1:0]    pos_q;
	logic [KIND_W-1:0]   run_kind_q;
	pend_t               pend_act_q;
	logic [KIND_W-1:0]   pend_kind_q;
	logic [CHAR_W-1:0]   pend_ch_q;
	mode_t               pend_mode_q;

	// Output holding register
	logic                m_valid_q;
	logic [CHAR_W-1:0]   m_ch_q;
	logic [POS_W-1:0]    m_pos_q;
	logic [KIND_W-1:0]   m_kind_q;
	logic                m_tend_q;
	logic                m_trunc_q;
	logic                m_last_q;

	// Decode of the incoming transaction
	csl_pkg::cls_t       cls;
	logic                in_fire;
	logic                run_grow;
	logic                has_run;
	pend_t               new_act;
	logic [KIND_W-1:0]   new_kind;
	mode_t               new_mode;

	logic                out_free;
	logic                emit_fire;
	logic                emit_last;
	logic                single_fire;
	logic [LEN_W-1:0]    pos_inc;
	logic                len_full;
	logic                kw_hit;

	// Shared write port into the cell chain and keyword tracker
	logic                wr_en;
	logic [LEN_W-1:0]    wr_idx;
	logic [CHAR_W-1:0]   wr_ch;
	csl_pkg::kw_ctl_t    kw_ctl;

	logic [CHAR_W-1:0]   cell_ch [NCELL];

	assign s_tready    = (state_q == ST_IDLE);
	assign in_fire     = s_tvalid && s_tready;
	assign out_free    = !m_valid_q || m_tready;
	assign pos_inc     = pos_q + LEN_W'(1);
	assign len_full    = (len_q >= LEN_W'(NCELL));
	assign emit_fire   = (state_q == ST_EMIT) && out_free;
	assign emit_last   = emit_fire && (pos_inc == len_q);
	assign single_fire = (state_q == ST_SINGLE) && out_free;
	assign has_run     = (mode_q != MODE_IDLE) && (len_q != '0);

	always_comb begin
		cls      = csl_pkg::char_class(s_tdata);
		run_grow = !s_tuser &&
			((mode_q == MODE_NUM && cls == csl_pkg::CLS_DIGIT) ||
			 (mode_q == MODE_WORD && (cls == csl_pkg::CLS_LETTER ||
			  cls == csl_pkg::CLS_DIGIT || cls == csl_pkg::CLS_UNDER)));
		new_act  = PEND_NONE;
		new_kind = csl_pkg::KIND_UNKNOWN;
		new_mode = MODE_IDLE;
		if (!s_tuser) begin
			unique case (cls)
				csl_pkg::CLS_SPACE: begin
					new_act = PEND_NONE;
				end
				csl_pkg::CLS_OP: begin
					new_act  = PEND_SINGLE;
					new_kind = csl_pkg::KIND_OP;
				end
				csl_pkg::CLS_PUNCT: begin
					new_act  = PEND_SINGLE;
					new_kind = csl_pkg::KIND_PUNCT;
				end
				csl_pkg::CLS_DIGIT: begin
					new_act  = PEND_START;
					new_mode = MODE_NUM;
				end
				csl_pkg::CLS_LETTER: begin
					new_act  = PEND_START;
					new_mode = MODE_WORD;
				end
				default: begin
					// an underscore cannot open a word: it is unknown like any stray byte
					new_act  = PEND_SINGLE;
					new_kind = csl_pkg::KIND_UNKNOWN;
				end
			endcase
		end
	end

	// Append to the run, open a new run straight away, or open the run that
	// was parked behind a flush as the last character leaves.
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = len_q;
		wr_ch  = s_tdata;
		priority if (in_fire && run_grow) begin
			wr_en = !len_full;
		end else if (in_fire && !has_run && new_act == PEND_START) begin
			wr_en  = 1'b1;
			wr_idx = '0;
		end else if (emit_last && pend_act_q == PEND_START) begin
			wr_en  = 1'b1;
			wr_idx = '0;
			wr_ch  = pend_ch_q;
		end else begin
			wr_en = 1'b0;
		end
	end

	assign kw_ctl = '{append: wr_en, pos: wr_idx, ch: wr_ch};

	csl_kw_track u_kw (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (kw_ctl),
		.len    (len_q),
		.ovf    (ovf_q),
		.is_kw  (kw_hit)
	);

	// Cell chain: each cell loads when addressed, and hands its character to
	// the cell below whenever a run character is emitted; cell 0 feeds the output.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		csl_pkg::cell_ctl_t ctl;
		logic [CHAR_W-1:0]  shift_in;

		assign ctl.load  = wr_en && (wr_idx == LEN_W'(i));
		assign ctl.shift = emit_fire;

		if (i == NCELL - 1) begin : g_tail
			assign shift_in = '0;
		end else begin : g_link
			assign shift_in = cell_ch[i + 1];
		end

		csl_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.load_ch  (wr_ch),
			.shift_in (shift_in),
			.ch_q     (cell_ch[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_IDLE;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			pos_q       <= '0;
			run_kind_q  <= '0;
			pend_act_q  <= PEND_NONE;
			pend_kind_q <= '0;
			pend_ch_q   <= '0;
			pend_mode_q <= MODE_IDLE;
			m_valid_q   <= 1'b0;
			m_ch_q      <= '0;
			m_pos_q     <= '0;
			m_kind_q    <= '0;
			m_tend_q    <= 1'b0;
			m_trunc_q   <= 1'b0;
			m_last_q    <= 1'b0;
		end else begin
			// drop the held result once the sink takes it, unless a new one follows
			if (m_tready && !emit_fire && !single_fire)
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (run_grow) begin
							// characters past the buffer are dropped and flagged
							if (!len_full)
								len_q <= len_q + LEN_W'(1);
							else
								ovf_q <= 1'b1;
						end else if (has_run) begin
							// flush the pending run first, park the new byte
							state_q     <= ST_EMIT;
							pos_q       <= '0;
							run_kind_q  <= (mode_q == MODE_NUM) ? csl_pkg::KIND_NUM :
								(kw_hit ? csl_pkg::KIND_KEYWORD : csl_pkg::KIND_IDENT);
							pend_act_q  <= new_act;
							pend_kind_q <= new_kind;
							pend_ch_q   <= s_tdata;
							pend_mode_q <= new_mode;
						end else begin
							pend_act_q  <= new_act;
							pend_kind_q <= new_kind;
							pend_ch_q   <= s_tdata;
							unique case (new_act)
								PEND_SINGLE: state_q <= ST_SINGLE;
								PEND_START: begin
									mode_q <= new_mode;
									len_q  <= LEN_W'(1);
								end
								default: state_q <= ST_IDLE;
							endcase
						end
					end
				end

				ST_EMIT: begin
					if (emit_fire) begin
						m_valid_q <= 1'b1;
						m_ch_q    <= cell_ch[0];
						m_pos_q   <= POS_W'(pos_q);
						m_kind_q  <= run_kind_q;
						m_tend_q  <= emit_last;
						m_trunc_q <= ovf_q;
						m_last_q  <= emit_last && (pend_act_q != PEND_SINGLE);
						pos_q     <= pos_inc;
						if (emit_last) begin
							ovf_q <= 1'b0;
							unique case (pend_act_q)
								PEND_SINGLE: begin
									mode_q  <= MODE_IDLE;
									len_q   <= '0;
									state_q <= ST_SINGLE;
								end
								PEND_START: begin
									// the parked byte opens the next run
									mode_q  <= pend_mode_q;
									len_q   <= LEN_W'(1);
									state_q <= ST_IDLE;
								end
								default: begin
									mode_q  <= MODE_IDLE;
									len_q   <= '0;
									state_q <= ST_IDLE;
								end
							endcase
						end
					end
				end

				ST_SINGLE: begin
					if (single_fire) begin
						m_valid_q <= 1'b1;
						m_ch_q    <= pend_ch_q;
						m_pos_q   <= '0;
						m_kind_q  <= pend_kind_q;
						m_tend_q  <= 1'b1;
						m_trunc_q <= 1'b0;
						m_last_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_pos_q, m_ch_q};
	assign m_tuser  = {m_trunc_q, m_tend_q, m_kind_q};
	assign m_tlast  = m_last_q;

	`CSL_ASSERT_ALWAYS(a_len_in_range, len_q <= LEN_W'(NCELL))
	`CSL_ASSERT_IMPL(a_idle_mode_empty, mode_q == MODE_IDLE, len_q == '0)
	`CSL_ASSERT_IMPL(a_ovf_only_when_full, ovf_q, len_q == LEN_W'(NCELL))
	`CSL_ASSERT_IMPL(a_emit_pos_below_len, state_q == ST_EMIT, pos_q < len_q)

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int MAX_TOKEN      = csl_pkg::MAX_TOKEN;
	localparam int KIND_W         = csl_pkg::KIND_W;
	localparam int POS_W          = csl_pkg::POS_W;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int REPORT_LIMIT   = 60;
	localparam int RANDOM_ITEMS   = 140;

	// One input transaction, with an optional hand-typed result for directed rows.
	typedef struct packed {
		logic [7:0]        ch;
		logic              eoi;
		logic              typed;
		logic              has_tok;
		logic [KIND_W-1:0] kind;
	} lex_item_t;

	// One output transaction: a single character of a token.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        ch;
		logic [POS_W-1:0]  pos;
		logic              tok_end;
		logic              trunc;
		logic              run_end;
	} tok_char_t;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_NUM,
		SCAN_WORD
	} scan_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	char_stream_lexer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lexer shadow state
	logic [7:0]  run_buf [MAX_TOKEN];
	int unsigned run_len;
	scan_t       run_mode;
	logic        run_ovf;

	string keywords [7] = '{"int", "return", "if", "else", "while", "float", "char"};

	tok_char_t expected_chars [$];
	lex_item_t stim [$];
	lex_item_t cur_item;

	int errors;
	int reports;
	int src_idle_pct;
	int snk_idle_pct;
	int stall_cycles;
	bit hold_req;

	// Directed rows: typed rows carry their result, the rest go through the shadow lexer.
	lex_item_t directed_rows [26] = '{
		'{8'hFF, 1'b1, 1'b1, 1'b0, csl_pkg::KIND_OP},      // end mark, nothing pending
		'{"+",   1'b0, 1'b1, 1'b1, csl_pkg::KIND_OP},
		'{8'h00, 1'b0, 1'b1, 1'b1, csl_pkg::KIND_UNKNOWN},
		'{8'hFF, 1'b0, 1'b1, 1'b1, csl_pkg::KIND_UNKNOWN},
		'{"_",   1'b0, 1'b1, 1'b1, csl_pkg::KIND_UNKNOWN}, // underscore cannot start a word
		'{"{",   1'b0, 1'b1, 1'b1, csl_pkg::KIND_PUNCT},
		'{" ",   1'b0, 1'b1, 1'b0, csl_pkg::KIND_OP},
		'{"i",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"f",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"(",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},      // keyword flushed, then punctuation
		'{"9",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"0",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"a",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},      // letter ends the number
		'{"_",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"Z",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"7",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},      // digit stays in the word
		'{8'h00, 1'b1, 1'b0, 1'b0, csl_pkg::KIND_OP},      // end mark flushes the word
		'{8'h09, 1'b0, 1'b1, 1'b0, csl_pkg::KIND_OP},
		'{"w",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"h",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"i",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"l",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{"e",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{8'h0A, 1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},      // newline ends the keyword
		'{"4",   1'b0, 1'b0, 1'b0, csl_pkg::KIND_OP},
		'{8'h01, 1'b1, 1'b0, 1'b0, csl_pkg::KIND_OP}
	};

	function automatic bit is_digit_c(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter_c(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic void push_char(logic [KIND_W-1:0] kind, logic [7:0] ch,
			logic [POS_W-1:0] pos, logic tok_end, logic trunc);
		tok_char_t t;
		t = '{kind, ch, pos, tok_end, trunc, 1'b0};
		expected_chars.push_back(t);
	endfunction

	function automatic void extend_run(logic [7:0] c);
		if (run_len < MAX_TOKEN) begin
			run_buf[run_len] = c;
			run_len++;
		end else begin
			run_ovf = 1'b1;
		end
	endfunction

	// Emit the buffered number or word, if any, and return to idle.
	function automatic void flush_run();
		logic [KIND_W-1:0] kind;
		bit kw;
		kw = 1'b0;
		if (run_mode != SCAN_IDLE && run_len != 0) begin
			if (run_mode == SCAN_NUM) begin
				kind = csl_pkg::KIND_NUM;
			end else begin
				// an overlong word is never a keyword
				if (!run_ovf) begin
					foreach (keywords[k]) begin
						bit same;
						same = (keywords[k].len() == run_len);
						for (int i = 0; same && i < run_len; i++)
							if (keywords[k][i] != run_buf[i])
								same = 1'b0;
						kw |= same;
					end
				end
				kind = kw ? csl_pkg::KIND_KEYWORD : csl_pkg::KIND_IDENT;
			end
			for (int i = 0; i < run_len; i++)
				push_char(kind, run_buf[i], POS_W'(i), (i + 1) == run_len, run_ovf);
		end
		run_mode = SCAN_IDLE;
		run_len  = 0;
		run_ovf  = 1'b0;
	endfunction

	// Advance the shadow lexer by one accepted transaction and queue what it emits.
	function automatic void lex_predict(lex_item_t it);
		int base;
		logic [7:0] c;
		base = expected_chars.size();
		c = it.ch;
		if (it.eoi) begin
			flush_run();
		end else if (run_mode == SCAN_NUM && is_digit_c(c)) begin
			extend_run(c);
		end else if (run_mode == SCAN_WORD &&
				(is_letter_c(c) || is_digit_c(c) || c == "_")) begin
			extend_run(c);
		end else begin
			flush_run();
			case (c)
				" ", 8'h0A, 8'h09: ;
				"+", "-", "*", "/", "=":
					push_char(csl_pkg::KIND_OP, c, '0, 1'b1, 1'b0);
				"(", ")", "{", "}", ";", ",":
					push_char(csl_pkg::KIND_PUNCT, c, '0, 1'b1, 1'b0);
				default: begin
					if (is_digit_c(c)) begin
						run_mode = SCAN_NUM;
						extend_run(c);
					end else if (is_letter_c(c)) begin
						run_mode = SCAN_WORD;
						extend_run(c);
					end else begin
						push_char(csl_pkg::KIND_UNKNOWN, c, '0, 1'b1, 1'b0);
					end
				end
			endcase
		end
		// hand-typed rows replace what the shadow lexer produced
		if (it.typed) begin
			while (expected_chars.size() > base)
				void'(expected_chars.pop_back());
			if (it.has_tok)
				push_char(it.kind, c, '0, 1'b1, 1'b0);
		end
		if (expected_chars.size() > base)
			expected_chars[expected_chars.size() - 1].run_end = 1'b1;
	endfunction

	function automatic void check_char();
		tok_char_t got;
		tok_char_t want;
		string got_s;
		string want_s;
		got = '{m_tuser[2:0], m_tdata[7:0], m_tdata[13:8], m_tuser[3], m_tuser[4], m_tlast};
		got_s = $sformatf("kind %0d ch %h pos %0d end %b trunc %b last %b pad %b",
			got.kind, got.ch, got.pos, got.tok_end, got.trunc, got.run_end, m_tdata[15:14]);
		if (expected_chars.size() == 0) begin
			errors++;
			if (reports++ < REPORT_LIMIT)
				$display("%0t: unexpected token char: %s", $time, got_s);
			return;
		end
		want = expected_chars.pop_front();
		want_s = $sformatf("kind %0d ch %h pos %0d end %b trunc %b last %b pad 00",
			want.kind, want.ch, want.pos, want.tok_end, want.trunc, want.run_end);
		if (got.kind !== want.kind || got.ch !== want.ch || got.pos !== want.pos ||
				got.tok_end !== want.tok_end || got.trunc !== want.trunc ||
				got.run_end !== want.run_end || m_tdata[15:14] !== 2'b00) begin
			errors++;
			if (reports++ < REPORT_LIMIT)
				$display("%0t: mismatch: expected %s, got %s", $time, want_s, got_s);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				lex_predict(cur_item);
			if (m_tvalid && m_tready)
				check_char();
		end
	end

	// Watchdog: end the run if no transaction moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	function automatic void queue_byte(logic [7:0] c, logic eoi);
		lex_item_t it;
		it = '{c, eoi, 1'b0, 1'b0, csl_pkg::KIND_OP};
		stim.push_back(it);
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? 8'("a" + c) : 8'("A" + c);
	endfunction

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return rand_letter();
		else if (r < 90)
			return 8'("0" + $urandom_range(0, 9));
		return "_";
	endfunction

	// Mostly well-formed source text with random content, plus noise bytes and end marks.
	function automatic void gen_tokens(int target);
		string ws     = " \n\t";
		string ops    = "+-*/=";
		string puncts = "(){};,";
		string kw;
		int r, n;
		while (stim.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				queue_byte(ws[$urandom_range(0, 2)], 1'b0);
			end else if (r < 24) begin
				queue_byte(ops[$urandom_range(0, 4)], 1'b0);
			end else if (r < 34) begin
				queue_byte(puncts[$urandom_range(0, 5)], 1'b0);
			end else if (r < 50) begin
				n = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 36) : $urandom_range(1, 5);
				repeat (n) queue_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
			end else if (r < 78) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					kw = keywords[$urandom_range(0, 6)];
					for (int i = 0; i < kw.len(); i++)
						queue_byte(kw[i], 1'b0);
					// a keyword with one more character is an identifier
					if (r >= 40)
						queue_byte(rand_word_char(), 1'b0);
				end else begin
					n = (r < 62) ? $urandom_range(29, 39) : $urandom_range(0, 7);
					queue_byte(rand_letter(), 1'b0);
					repeat (n) queue_byte(rand_word_char(), 1'b0);
				end
			end else if (r < 86) begin
				queue_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 93) begin
				queue_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				queue_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
					: 8'($urandom_range(0, 8)), 1'b0);
			end
		end
		queue_byte(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	// Offer one transaction; entered and left at a falling edge.
	task automatic send_item(lex_item_t it);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		cur_item = it;
		s_tvalid <= 1'b1;
		s_tdata  <= it.ch;
		s_tuser  <= it.eoi;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Hold the input idle until every outstanding token character has arrived.
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (expected_chars.size() != 0);
	endtask

	initial begin
		int half;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		hold_req = 1'b0;
		errors   = 0;
		reports  = 0;
		run_len  = 0;
		run_mode = SCAN_IDLE;
		run_ovf  = 1'b0;
		src_idle_pct = 11;
		snk_idle_pct = 73;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin src_idle_pct = 11; snk_idle_pct = 73; end
				1: begin src_idle_pct = 73; snk_idle_pct = 11; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			stim.delete();
			if (p == 0)
				foreach (directed_rows[i]) stim.push_back(directed_rows[i]);
			gen_tokens(stim.size() + RANDOM_ITEMS);
			half = stim.size() / 2;
			for (int i = 0; i < stim.size(); i++) begin
				if (i == half && p == 1)
					pause_until_drained();
				// receiver stalls while the sender keeps offering, so the block backs up
				if (i == half && p == 2)
					hold_req = 1'b1;
				send_item(stim[i]);
			end
			pause_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			errors += expected_chars.size();
			$display("%0t: %0d token chars never arrived", $time, expected_chars.size());
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
